@@ sv/jhtd_pkg.sv @@
package jhtd_pkg;

  // table geometry
  localparam int unsigned COUNT_BYTES     = 16;
  localparam int unsigned MAX_CODE_LEN    = 16;
  localparam int unsigned MAX_SYMBOLS_DEF = 256;

  // internal widths
  localparam int unsigned CODE_W = 16;  // code accumulator
  localparam int unsigned FC_W   = 17;  // canonical code at full scale
  localparam int unsigned POS_W  = 9;   // bytes consumed by a load
  localparam int unsigned TOT_W  = 12;  // sum of sixteen count bytes
  localparam int unsigned LEN_W  = 5;   // code length 0..16
  localparam int unsigned IDX_W  = 4;   // length table index

  // input actions
  localparam logic [1:0] ACT_BEGIN = 2'd0;
  localparam logic [1:0] ACT_BYTE  = 2'd1;
  localparam logic [1:0] ACT_BIT   = 2'd2;

  // result kinds
  typedef enum logic [2:0] {
    KIND_SYMBOL   = 3'd0,
    KIND_LOADED   = 3'd1,
    KIND_TOO_MANY = 3'd2,
    KIND_OVERSUB  = 3'd3,
    KIND_INVALID  = 3'd4
  } kind_t;

  // table load progress
  typedef enum logic [1:0] {
    PH_NONE    = 2'd0,
    PH_COUNTS  = 2'd1,
    PH_SYMBOLS = 2'd2,
    PH_READY   = 2'd3
  } phase_t;

  // control sequencer
  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_BUILD = 2'd1,
    ST_EMIT  = 2'd2
  } state_t;

endpackage

@@ sv/jhtd_ram.sv @@
module jhtd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ sv/jpeg_huffman_table_decoder.sv @@
// channel  ports                                      direction
// -------  -----------------------------------------  ---------
// input    in_valid, in_stall, in_action, in_data     in
// result   out_valid, out_stall, out_kind, out_symbol,
//          out_code_length, out_table_bytes           out
//
// A begin, a byte or a code bit that ends nothing is taken in idle. A code bit that
// ends a code and the last symbol byte pass through emit (symbol from the registered
// read). The 16th count byte goes to emit on too many symbols, else to the canonical
// build, one length per cycle, up to 16 (stops when oversubscribed), emit for a result.
// Reset is synchronous and needs no clearing pass. A result waits under out_stall
// while the next transaction is taken; a second result holds in_stall until then.
module jpeg_huffman_table_decoder #(
  parameter int unsigned MAX_SYMBOLS = jhtd_pkg::MAX_SYMBOLS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_action,
  input  logic [7:0] in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_kind,
  output logic [7:0] out_symbol,
  output logic [4:0] out_code_length,
  output logic [8:0] out_table_bytes
);

  import jhtd_pkg::*;

  localparam int unsigned AW = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
  localparam logic [TOT_W-1:0] MAX_SYM_V = TOT_W'(MAX_SYMBOLS);

  // control registers
  state_t              state_r, state_nxt;
  phase_t              phase_r, phase_nxt;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic [TOT_W-1:0]    total_r, total_nxt;

  // code bit shift registers
  logic [CODE_W-1:0]   acc_r, acc_nxt;
  logic [CODE_W-1:0]   scaled_r, scaled_nxt;
  logic [CODE_W-1:0]   mask_r, mask_nxt;
  logic [IDX_W-1:0]    bits_r, bits_nxt;

  // canonical build iteration
  logic [IDX_W-1:0]    bld_idx_r, bld_idx_nxt;
  logic [FC_W-1:0]     bld_code_r, bld_code_nxt;
  logic [POS_W-1:0]    bld_fi_r, bld_fi_nxt;
  logic [FC_W-1:0]     ncc_r, ncc_nxt;

  // length tables
  logic [7:0]          counts_r [COUNT_BYTES];
  logic [FC_W-1:0]     fc_r [COUNT_BYTES];
  logic [POS_W-1:0]    fi_r [COUNT_BYTES];
  logic                cnt_we;
  logic                bld_we;

  // pending and output results
  kind_t               res_kind_r, res_kind_nxt;
  logic [LEN_W-1:0]    res_len_r, res_len_nxt;
  logic [POS_W-1:0]    res_bytes_r, res_bytes_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [2:0]          out_kind_r;
  logic [7:0]          out_symbol_r;
  logic [LEN_W-1:0]    out_code_length_r;
  logic [POS_W-1:0]    out_table_bytes_r;
  logic                out_load;

  // symbol store
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic                ram_re;
  logic [AW-1:0]       ram_raddr;
  logic [7:0]          ram_rdata;

  // datapath terms
  logic                accept;
  logic [TOT_W-1:0]    total_sum;
  logic [POS_W-1:0]    sym_idx;
  logic [POS_W-1:0]    sym_done;
  logic [CODE_W-1:0]   acc_new;
  logic [CODE_W-1:0]   scaled_new;
  logic [LEN_W-1:0]    len_new;
  logic [7:0]          dec_cnt;
  logic [FC_W-1:0]     dec_fc;
  logic [POS_W-1:0]    dec_fi;
  logic [FC_W-1:0]     dec_off;
  logic                dec_hit;
  logic                dec_fail;
  logic [7:0]          bld_cnt;
  logic [FC_W:0]       bld_sum;
  logic [FC_W:0]       bld_limit;
  logic                bld_over;
  logic                bld_last;

  assign accept = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);

  // load byte bookkeeping
  assign total_sum = total_r + TOT_W'(in_data);
  assign sym_idx   = pos_r - POS_W'(COUNT_BYTES);
  assign sym_done  = sym_idx + POS_W'(1);

  // one code bit: canonical compare at the current length
  assign acc_new    = {acc_r[CODE_W-2:0], in_data[0]};
  assign scaled_new = scaled_r | (in_data[0] ? mask_r : '0);
  assign len_new    = LEN_W'(bits_r) + LEN_W'(1);
  assign dec_cnt    = counts_r[bits_r];
  assign dec_fc     = fc_r[bits_r];
  assign dec_fi     = fi_r[bits_r];
  assign dec_off    = {1'b0, acc_new} - dec_fc;
  assign dec_hit    = ({1'b0, acc_new} >= dec_fc) && (dec_off < FC_W'(dec_cnt));
  assign dec_fail   = (len_new >= LEN_W'(MAX_CODE_LEN)) || (len_new >= LEN_W'(COUNT_BYTES))
                      || ({1'b0, scaled_new} >= ncc_r);
  assign ram_raddr  = AW'(dec_fi + dec_off[POS_W-1:0]);

  // one length of the canonical build
  assign bld_cnt   = counts_r[bld_idx_r];
  assign bld_sum   = {1'b0, bld_code_r} + (FC_W+1)'(bld_cnt);
  assign bld_limit = (FC_W+1)'(2) << bld_idx_r;
  assign bld_over  = bld_sum > bld_limit;
  assign bld_last  = (bld_idx_r == IDX_W'(COUNT_BYTES - 1));

  assign ram_waddr = AW'(sym_idx);

  // sequencer, next state and datapath control
  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    pos_nxt       = pos_r;
    total_nxt     = total_r;
    acc_nxt       = acc_r;
    scaled_nxt    = scaled_r;
    mask_nxt      = mask_r;
    bits_nxt      = bits_r;
    bld_idx_nxt   = bld_idx_r;
    bld_code_nxt  = bld_code_r;
    bld_fi_nxt    = bld_fi_r;
    ncc_nxt       = ncc_r;
    res_kind_nxt  = res_kind_r;
    res_len_nxt   = res_len_r;
    res_bytes_nxt = res_bytes_r;
    cnt_we        = 1'b0;
    bld_we        = 1'b0;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    out_load      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_action)
            ACT_BEGIN: begin
              pos_nxt    = '0;
              total_nxt  = '0;
              phase_nxt  = PH_COUNTS;
              acc_nxt    = '0;
              scaled_nxt = '0;
              mask_nxt   = CODE_W'(1) << (CODE_W - 1);
              bits_nxt   = '0;
            end
            ACT_BYTE: begin
              if (phase_r == PH_COUNTS) begin
                cnt_we    = 1'b1;
                total_nxt = total_sum;
                pos_nxt   = pos_r + POS_W'(1);
                if (pos_r == POS_W'(COUNT_BYTES - 1)) begin
                  if (total_sum > MAX_SYM_V) begin
                    phase_nxt     = PH_NONE;
                    res_kind_nxt  = KIND_TOO_MANY;
                    res_len_nxt   = '0;
                    res_bytes_nxt = '0;
                    state_nxt     = ST_EMIT;
                  end else begin
                    bld_idx_nxt  = '0;
                    bld_code_nxt = '0;
                    bld_fi_nxt   = '0;
                    state_nxt    = ST_BUILD;
                  end
                end
              end else if (phase_r == PH_SYMBOLS) begin
                ram_we  = 1'b1;
                pos_nxt = pos_r + POS_W'(1);
                if (TOT_W'(sym_done) >= total_r) begin
                  phase_nxt     = PH_READY;
                  res_kind_nxt  = KIND_LOADED;
                  res_len_nxt   = '0;
                  res_bytes_nxt = pos_r + POS_W'(1);
                  state_nxt     = ST_EMIT;
                end
              end
            end
            ACT_BIT: begin
              if (phase_r != PH_READY || dec_hit || dec_fail) begin
                acc_nxt       = '0;
                scaled_nxt    = '0;
                mask_nxt      = CODE_W'(1) << (CODE_W - 1);
                bits_nxt      = '0;
                res_len_nxt   = '0;
                res_bytes_nxt = '0;
                state_nxt     = ST_EMIT;
                if (phase_r == PH_READY && dec_hit) begin
                  ram_re       = 1'b1;
                  res_kind_nxt = KIND_SYMBOL;
                  res_len_nxt  = len_new;
                end else begin
                  res_kind_nxt = KIND_INVALID;
                end
              end else begin
                acc_nxt    = acc_new;
                scaled_nxt = scaled_new;
                mask_nxt   = mask_r >> 1;
                bits_nxt   = bits_r + IDX_W'(1);
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_BUILD: begin
        bld_we = 1'b1;
        if (bld_over) begin
          phase_nxt     = PH_NONE;
          res_kind_nxt  = KIND_OVERSUB;
          res_len_nxt   = '0;
          res_bytes_nxt = '0;
          state_nxt     = ST_EMIT;
        end else if (bld_last) begin
          ncc_nxt = bld_sum[FC_W-1:0];
          if (total_r == '0) begin
            phase_nxt     = PH_READY;
            res_kind_nxt  = KIND_LOADED;
            res_len_nxt   = '0;
            res_bytes_nxt = pos_r;
            state_nxt     = ST_EMIT;
          end else begin
            phase_nxt = PH_SYMBOLS;
            state_nxt = ST_IDLE;
          end
        end else begin
          bld_idx_nxt  = bld_idx_r + IDX_W'(1);
          bld_code_nxt = {bld_sum[FC_W-2:0], 1'b0};
          bld_fi_nxt   = bld_fi_r + POS_W'(bld_cnt);
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // output register valid
  assign out_valid_nxt = out_load || (out_valid_r && out_stall);

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= PH_NONE;
      pos_r       <= '0;
      total_r     <= '0;
      acc_r       <= '0;
      scaled_r    <= '0;
      mask_r      <= CODE_W'(1) << (CODE_W - 1);
      bits_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      pos_r       <= pos_nxt;
      total_r     <= total_nxt;
      acc_r       <= acc_nxt;
      scaled_r    <= scaled_nxt;
      mask_r      <= mask_nxt;
      bits_r      <= bits_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // build iteration and pending result payload
  always_ff @(posedge clk) begin
    bld_idx_r   <= bld_idx_nxt;
    bld_code_r  <= bld_code_nxt;
    bld_fi_r    <= bld_fi_nxt;
    ncc_r       <= ncc_nxt;
    res_kind_r  <= res_kind_nxt;
    res_len_r   <= res_len_nxt;
    res_bytes_r <= res_bytes_nxt;
  end

  // length tables
  always_ff @(posedge clk) begin
    if (cnt_we) begin
      counts_r[pos_r[IDX_W-1:0]] <= in_data;
    end
    if (bld_we) begin
      fc_r[bld_idx_r] <= bld_code_r;
      fi_r[bld_idx_r] <= bld_fi_r;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_kind_r        <= res_kind_r;
      out_symbol_r      <= (res_kind_r == KIND_SYMBOL) ? ram_rdata : '0;
      out_code_length_r <= res_len_r;
      out_table_bytes_r <= res_bytes_r;
    end
  end

  jhtd_ram #(
    .WIDTH (8),
    .DEPTH (MAX_SYMBOLS)
  ) u_symbol_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (in_data),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  assign out_valid       = out_valid_r;
  assign out_kind        = out_kind_r;
  assign out_symbol      = out_symbol_r;
  assign out_code_length = out_code_length_r;
  assign out_table_bytes = out_table_bytes_r;

`ifndef SYNTHESIS
  // a decoded symbol always carries a real code length
  a_sym_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == KIND_SYMBOL) |->
      (out_code_length != '0 && out_code_length <= LEN_W'(MAX_CODE_LEN)))
    else $error("symbol result with bad code length");

  // a finished load has consumed at least the count bytes
  a_load_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == KIND_LOADED) |-> (out_table_bytes >= POS_W'(COUNT_BYTES)))
    else $error("table loaded with too few bytes");

  // the build only starts out of the count phase
  a_build_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_BUILD && $past(state_r) != ST_BUILD) |-> ($past(phase_r) == PH_COUNTS))
    else $error("canonical build entered outside count phase");

  // scale mask marks exactly one bit position
  a_mask_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(mask_r))
    else $error("code scale mask not one-hot");

  // partial code bits exist only with a ready table
  a_bits_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (bits_r != '0) |-> (phase_r == PH_READY))
    else $error("partial code held without a ready table");
`endif

endmodule

@@ bench/jpeg_huffman_table_decoder_tb.sv @@
`timescale 1ns / 1ps

module jpeg_huffman_table_decoder_tb;
  import jhtd_pkg::*;

  localparam logic [1:0] ACT_RESERVED = 2'd3;
  localparam int unsigned QUIET_LIMIT = 3000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned RANDOM_ITEMS = 650;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] data;
  } stim_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] symbol;
    logic [4:0] code_length;
    logic [8:0] table_bytes;
  } result_t;

  logic       clk;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] in_action = ACT_BEGIN;
  logic [7:0] in_data = 8'd0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [2:0] out_kind;
  logic [7:0] out_symbol;
  logic [4:0] out_code_length;
  logic [8:0] out_table_bytes;

  stim_t   pending_items[$];
  result_t expected_results[$];
  stim_t   drive_item;
  result_t want;

  // decoder state as predicted from accepted transactions
  logic [7:0]  tbl_counts[16];
  logic [16:0] tbl_first_code[16];
  logic [8:0]  tbl_first_index[16];
  logic [7:0]  tbl_symbols[256];
  int unsigned code_space;
  int unsigned load_bytes;
  int unsigned sym_total;
  phase_t      tbl_phase;
  int unsigned code_acc;
  int unsigned code_bits;

  // stimulus bookkeeping
  int unsigned gen_counts[16];
  int unsigned stim_items;
  int unsigned items_accepted = 0;
  int unsigned quiet_cycles = 0;
  int unsigned err_count = 0;
  int unsigned results_checked = 0;
  int unsigned tables_loaded = 0;
  int unsigned symbols_decoded = 0;
  int unsigned invalid_codes = 0;
  int unsigned load_failures = 0;
  int unsigned idle_phase;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;

  jpeg_huffman_table_decoder u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_action       (in_action),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kind        (out_kind),
    .out_symbol      (out_symbol),
    .out_code_length (out_code_length),
    .out_table_bytes (out_table_bytes)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // idling phases rotate with progress: none, sender, receiver, both, none
  assign idle_phase    = (items_accepted / 60) % 5;
  assign send_idle_pct = (idle_phase == 1) ? 45 : (idle_phase == 3) ? 8 : 0;
  assign recv_idle_pct = (idle_phase == 2) ? 45 : (idle_phase == 3) ? 8 : 0;

  function automatic void log_mismatch(string msg);
    err_count++;
    if (err_count <= 10) $display("ERROR @%0t: %s", $realtime, msg);
  endfunction

  task automatic reset_decoder_state();
    foreach (tbl_counts[i]) begin
      tbl_counts[i] = '0;
      tbl_first_code[i] = '0;
      tbl_first_index[i] = '0;
    end
    foreach (tbl_symbols[i]) tbl_symbols[i] = '0;
    code_space = 0;
    load_bytes = 0;
    sym_total = 0;
    tbl_phase = PH_NONE;
    code_acc = 0;
    code_bits = 0;
  endtask

  // expected decoder response to one accepted transaction
  task automatic predict_decoder(input logic [1:0] act, input logic [7:0] dat);
    result_t     r;
    bit          hit;
    bit          oversub;
    int unsigned code;
    int unsigned idx;
    int unsigned len;
    int unsigned cnt;
    int unsigned fc;
    r = '{KIND_SYMBOL, 8'd0, 5'd0, 9'd0};
    hit = 1'b0;
    case (act)
      ACT_BEGIN: begin
        foreach (tbl_counts[i]) tbl_counts[i] = '0;
        load_bytes = 0;
        sym_total = 0;
        code_space = 0;
        tbl_phase = PH_COUNTS;
        code_acc = 0;
        code_bits = 0;
      end
      ACT_BYTE: begin
        if (tbl_phase == PH_COUNTS) begin
          tbl_counts[load_bytes % 16] = dat;
          sym_total += dat;
          load_bytes++;
          if (load_bytes == COUNT_BYTES) begin
            hit = 1'b1;
            if (sym_total > MAX_SYMBOLS_DEF) begin
              tbl_phase = PH_NONE;
              r.kind = KIND_TOO_MANY;
            end else begin
              // canonical bounds, stopping at the first oversubscribed length
              code = 0;
              idx = 0;
              oversub = 1'b0;
              for (int l = 0; l < 16 && !oversub; l++) begin
                tbl_first_code[l] = 17'(code);
                tbl_first_index[l] = 9'(idx);
                if (code + tbl_counts[l] > (32'd1 << (l + 1))) begin
                  oversub = 1'b1;
                end else begin
                  idx += tbl_counts[l];
                  code += tbl_counts[l];
                  if (l < 15) code = code << 1;
                end
              end
              if (oversub) begin
                tbl_phase = PH_NONE;
                r.kind = KIND_OVERSUB;
              end else begin
                code_space = code & 32'h1FFFF;
                if (sym_total == 0) begin
                  tbl_phase = PH_READY;
                  r.kind = KIND_LOADED;
                  r.table_bytes = 9'(load_bytes);
                end else begin
                  tbl_phase = PH_SYMBOLS;
                  hit = 1'b0;
                end
              end
            end
          end
        end else if (tbl_phase == PH_SYMBOLS) begin
          tbl_symbols[(load_bytes - COUNT_BYTES) % 256] = dat;
          load_bytes++;
          if (load_bytes - COUNT_BYTES >= sym_total) begin
            tbl_phase = PH_READY;
            hit = 1'b1;
            r.kind = KIND_LOADED;
            r.table_bytes = 9'(load_bytes);
          end
        end
      end
      ACT_BIT: begin
        hit = 1'b1;
        if (tbl_phase != PH_READY) begin
          code_acc = 0;
          code_bits = 0;
          r.kind = KIND_INVALID;
        end else begin
          code_acc = ((code_acc << 1) | dat[0]) & 32'hFFFF;
          code_bits++;
          len = code_bits;
          cnt = tbl_counts[(len - 1) % 16];
          fc = tbl_first_code[(len - 1) % 16];
          if (code_acc >= fc && code_acc - fc < cnt) begin
            r.kind = KIND_SYMBOL;
            r.symbol = tbl_symbols[(tbl_first_index[(len - 1) % 16] + code_acc - fc) % 256];
            r.code_length = 5'(len);
            code_acc = 0;
            code_bits = 0;
          end else if (len >= MAX_CODE_LEN || (code_acc << (16 - len)) >= code_space) begin
            r.kind = KIND_INVALID;
            code_acc = 0;
            code_bits = 0;
          end else begin
            hit = 1'b0;
          end
        end
      end
      default: ;
    endcase
    if (hit) expected_results.push_back(r);
  endtask

  // input driver: a new transaction goes out once the current one is taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_decoder(in_action, in_data);
        items_accepted <= items_accepted + 1;
      end
      if (!in_valid || !in_stall) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          drive_item = pending_items.pop_front();
          in_valid <= 1'b1;
          in_action <= drive_item.action;
          in_data <= drive_item.data;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stall
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_checked++;
        if (expected_results.size() == 0) begin
          log_mismatch($sformatf("unexpected result: kind %0d symbol %0h length %0d bytes %0d",
                                 out_kind, out_symbol, out_code_length, out_table_bytes));
        end else begin
          want = expected_results.pop_front();
          if (out_kind !== want.kind || out_symbol !== want.symbol ||
              out_code_length !== want.code_length || out_table_bytes !== want.table_bytes) begin
            log_mismatch($sformatf({"result %0d: kind %0d/%0d symbol %0h/%0h ",
                                    "length %0d/%0d bytes %0d/%0d (expected/actual)"},
                                   results_checked, want.kind, out_kind, want.symbol,
                                   out_symbol, want.code_length, out_code_length,
                                   want.table_bytes, out_table_bytes));
          end
          case (want.kind)
            KIND_SYMBOL:  symbols_decoded++;
            KIND_LOADED:  tables_loaded++;
            KIND_INVALID: invalid_codes++;
            default:      load_failures++;
          endcase
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  task automatic push_item(input logic [1:0] act, input logic [7:0] dat);
    pending_items.push_back('{act, dat});
    if (act != ACT_RESERVED) stim_items++;
  endtask

  // begin, the 16 count bytes from gen_counts, and optionally random symbols
  task automatic load_table(input bit with_symbols);
    int unsigned total;
    total = 0;
    push_item(ACT_BEGIN, 8'($urandom));
    for (int i = 0; i < 16; i++) begin
      push_item(ACT_BYTE, 8'(gen_counts[i]));
      total += gen_counts[i];
    end
    if (with_symbols) begin
      for (int i = 0; i < total; i++) begin
        case ($urandom_range(9))
          0:       push_item(ACT_BYTE, 8'h00);
          1:       push_item(ACT_BYTE, 8'hFF);
          default: push_item(ACT_BYTE, 8'($urandom));
        endcase
      end
    end
  endtask

  function automatic int unsigned canon_code(input int unsigned len, input int unsigned k);
    int unsigned c;
    c = 0;
    for (int l = 1; l < len; l++) c = (c + gen_counts[l - 1]) << 1;
    return c + k;
  endfunction

  // code bits go out msb first, upper data bits random
  task automatic send_code(input int unsigned value, input int unsigned nbits);
    for (int i = nbits - 1; i >= 0; i--) begin
      push_item(ACT_BIT, {7'($urandom), 1'(value >> i)});
    end
  endtask

  // a mix of real codes, codes just past the used space, and loose bits
  task automatic send_codes(input int unsigned n);
    int unsigned used_lens[$];
    int unsigned len;
    int unsigned pick;
    int unsigned value;
    for (int l = 1; l <= 16; l++) begin
      if (gen_counts[l - 1] != 0) used_lens.push_back(l);
    end
    repeat (n) begin
      pick = $urandom_range(99);
      if (used_lens.size() != 0 && pick < 88) begin
        len = used_lens[$urandom_range(used_lens.size() - 1)];
        if (pick < 75) begin
          send_code(canon_code(len, $urandom_range(gen_counts[len - 1] - 1)), len);
        end else begin
          value = canon_code(len, gen_counts[len - 1]);
          if (value < (32'd1 << len)) send_code(value, len);
        end
      end else begin
        repeat ($urandom_range(1, 3)) push_item(ACT_BIT, 8'($urandom));
      end
    end
  endtask

  // random lengths kept within the code space
  task automatic make_valid_counts(input int unsigned nsym);
    int unsigned kraft;
    int unsigned len;
    foreach (gen_counts[i]) gen_counts[i] = 0;
    kraft = 0;
    repeat (nsym) begin
      len = ($urandom_range(3) == 0) ? 16 : $urandom_range(1, 16);
      if (kraft + (32'd1 << (16 - len)) <= 32'h10000) begin
        kraft += 32'd1 << (16 - len);
        gen_counts[len - 1]++;
      end
    end
    if (kraft == 0) gen_counts[$urandom_range(15)] = 1;
  endtask

  initial begin
    int unsigned pick;
    int unsigned sum;
    int unsigned l;
    bit          big_done;
    reset_decoder_state();
    stim_items = 0;
    big_done = 1'b0;

    // directed: idle-state inputs, an aborted load, then lengths 1 and 16
    push_item(ACT_BIT, 8'hFE);
    push_item(ACT_BYTE, 8'hFF);
    push_item(ACT_RESERVED, 8'hFF);
    push_item(ACT_BEGIN, 8'h00);
    push_item(ACT_BYTE, 8'h00);
    foreach (gen_counts[i]) gen_counts[i] = 0;
    gen_counts[0] = 1;
    gen_counts[15] = 1;
    load_table(1'b0);
    push_item(ACT_BYTE, 8'hFF);
    push_item(ACT_BYTE, 8'h00);
    push_item(ACT_BIT, 8'h00);

    // random table loads and decode streams
    while (stim_items < RANDOM_ITEMS + 25) begin
      pick = $urandom_range(99);
      if (!big_done && stim_items > 250) begin
        // largest table: 256 symbols, 272 bytes
        big_done = 1'b1;
        foreach (gen_counts[i]) gen_counts[i] = 0;
        gen_counts[7] = 254;
        gen_counts[15] = 2;
        load_table(1'b1);
        send_codes(12);
      end else if (pick < 60) begin
        make_valid_counts(($urandom_range(9) == 0) ? $urandom_range(17, 60)
                                                   : $urandom_range(1, 10));
        load_table(1'b1);
        send_codes($urandom_range(3, 16));
      end else if (pick < 68) begin
        foreach (gen_counts[i]) gen_counts[i] = 0;
        load_table(1'b0);
        send_codes($urandom_range(1, 3));
      end else if (pick < 76) begin
        if ($urandom_range(1) == 0) begin
          foreach (gen_counts[i]) gen_counts[i] = $urandom_range(255);
          sum = 0;
          foreach (gen_counts[i]) sum += gen_counts[i];
          if (sum <= 256) gen_counts[15] = 255;
        end else begin
          // one symbol over the limit
          foreach (gen_counts[i]) gen_counts[i] = 0;
          gen_counts[15] = 255;
          gen_counts[14] = 2;
        end
        load_table(1'b0);
        push_item(ACT_BIT, 8'($urandom));
      end else if (pick < 84) begin
        foreach (gen_counts[i]) gen_counts[i] = 0;
        l = $urandom_range(6);
        gen_counts[l] = (32'd1 << (l + 1)) + $urandom_range(1, 3);
        gen_counts[15] = $urandom_range(5);
        load_table(1'b0);
        push_item(ACT_BIT, 8'($urandom));
      end else if (pick < 92) begin
        // load cut short, bits sent while still loading
        push_item(ACT_BEGIN, 8'($urandom));
        repeat ($urandom_range(1, 20)) push_item(ACT_BYTE, 8'($urandom_range(3)));
        repeat ($urandom_range(1, 2)) push_item(ACT_BIT, 8'($urandom));
      end else begin
        repeat ($urandom_range(1, 4)) push_item(2'($urandom), 8'($urandom));
      end
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (expected_results.size() != 0) begin
      log_mismatch($sformatf("%0d expected results never arrived", expected_results.size()));
    end
    $display("run: %0d transactions in, %0d results checked, %0d mismatches",
             items_accepted, results_checked, err_count);
    $display("run: %0d tables loaded, %0d load errors, %0d symbols, %0d invalid codes",
             tables_loaded, load_failures, symbols_decoded, invalid_codes);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ jpeg_huffman_table_decoder.f @@
sv/jhtd_pkg.sv
sv/jhtd_ram.sv
sv/jpeg_huffman_table_decoder.sv
bench/jpeg_huffman_table_decoder_tb.sv
